### rtl/rtpfua_pkg.sv
// Shared types, constants and codes for the RTP H.264 FU-A packetizer.
// No dependencies; every other file of the block imports this package.
package rtpfua_pkg;

   // Field and register widths
   localparam int LEN_W      = 16;  // unit length and byte position
   localparam int LIMIT_W    = 12;  // payload limit and fragment fill
   localparam int PT_W       = 7;
   localparam int WORD_W     = 32;  // timestamp, SSRC, widest register
   localparam int SEQ_W      = 16;
   localparam int ACTION_W   = 2;
   localparam int CSR_IDX_W  = 2;

   // Input action codes
   localparam logic [ACTION_W-1:0] ACT_NAL_BYTE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SET_TS   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_ADD_TS   = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_TYPE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SSRC_ID      = 2'd2;

   // Register reset values
   localparam logic [LIMIT_W-1:0] MAX_PAYLOAD_RST  = 12'd1200;
   localparam logic [PT_W-1:0]    PAYLOAD_TYPE_RST = 7'd96;
   localparam logic [WORD_W-1:0]  SSRC_ID_RST      = 32'h1357_9BDF;
   localparam logic [SEQ_W-1:0]   SEQ_RST          = 16'd1;

   // Packet format constants
   localparam logic [LEN_W-1:0]   START_CODE_BYTES = 16'd4;
   localparam logic [LIMIT_W-1:0] MIN_LIMIT        = 12'd3;
   localparam logic [LIMIT_W-1:0] FU_OVERHEAD      = 12'd2;
   localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
   localparam logic [7:0] NRI_MASK         = 8'hE0;
   localparam logic [7:0] FU_A_TYPE        = 8'd28;
   localparam logic [7:0] FU_START_BIT     = 8'h80;
   localparam logic [7:0] FU_END_BIT       = 8'h40;
   localparam logic [7:0] NAL_TYPE_MASK    = 8'h1F;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // Byte cursor of the back end: header 0..11, FU bytes 12..13, data 14
   localparam int CUR_W = 4;
   localparam logic [CUR_W-1:0] CUR_HDR_LAST = 4'd11;
   localparam logic [CUR_W-1:0] CUR_FU_IND   = 4'd12;
   localparam logic [CUR_W-1:0] CUR_FU_HDR   = 4'd13;
   localparam logic [CUR_W-1:0] CUR_DATA     = 4'd14;

   // One queued job: optional RTP header, optional FU bytes, one data byte
   typedef struct packed {
      logic              has_hdr;
      logic              has_fu;
      logic              marker;
      logic [SEQ_W-1:0]  seq;
      logic [WORD_W-1:0] ts;
      logic [7:0]        fu_ind;
      logic [7:0]        fu_hdr;
      logic [7:0]        data;
      logic              pkt_end;
   } job_type;

endpackage

### rtl/rtpfua_front.sv
// Front end: accepts transactions, tracks unit and fragment state, and
// turns each payload byte into a job. Depends on rtpfua_pkg.
module rtpfua_front import rtpfua_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [ACTION_W-1:0] action,
   input  logic [7:0]          data_byte,
   input  logic                nal_start,
   input  logic [LEN_W-1:0]    nal_length,
   input  logic                frame_mark,
   input  logic [WORD_W-1:0]   ts_value,
   input  logic [LIMIT_W-1:0]  max_payload,
   output logic                job_push,
   output job_type             job
);

   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [WORD_W-1:0]  ts_ff, ts_in;
   logic [LEN_W-1:0]   bpos_ff, bpos_in;
   logic [LEN_W-1:0]   ulen_ff, ulen_in;
   logic [7:0]         nalh_ff, nalh_in;
   logic               mark_ff, mark_in;
   logic               frag_ff, frag_in;
   logic               active_ff, active_in;
   logic [LIMIT_W-1:0] fill_ff, fill_in;

   logic [LIMIT_W-1:0] limit;
   logic [LIMIT_W-1:0] cap;
   logic [LEN_W-1:0]   off;
   logic [LEN_W-1:0]   nlen;
   logic [LIMIT_W-1:0] fill_next;
   logic               last_byte;
   logic               last_frag;

   // Effective payload limit and fragment capacity
   assign limit = (max_payload < MIN_LIMIT) ? MIN_LIMIT : max_payload;
   assign cap   = limit - FU_OVERHEAD;

   // Classification and state update for one transaction
   always_comb begin
      seq_in    = seq_ff;
      ts_in     = ts_ff;
      bpos_in   = bpos_ff;
      ulen_in   = ulen_ff;
      nalh_in   = nalh_ff;
      mark_in   = mark_ff;
      frag_in   = frag_ff;
      active_in = active_ff;
      fill_in   = fill_ff;
      job_push  = 1'b0;
      job       = '0;
      job.seq   = seq_ff;
      job.ts    = ts_ff;
      job.data  = data_byte;
      off       = '0;
      nlen      = '0;
      fill_next = '0;
      last_byte = 1'b0;
      last_frag = 1'b0;
      if (accept) begin
         case (action)
            ACT_SET_TS: ts_in = ts_value;
            ACT_ADD_TS: ts_in = ts_ff + ts_value;
            ACT_NAL_BYTE: begin
               // New unit: latch length and mark, decide fragmentation
               if (nal_start) begin
                  ulen_in   = nal_length;
                  mark_in   = frame_mark;
                  bpos_in   = '0;
                  fill_in   = '0;
                  active_in = nal_length >= (START_CODE_BYTES + 16'd1);
                  frag_in   = active_in &&
                              ((nal_length - START_CODE_BYTES) > {4'b0, limit});
               end
               if (active_in && (bpos_in < ulen_in)) begin
                  off       = bpos_in - START_CODE_BYTES;
                  nlen      = ulen_in - START_CODE_BYTES;
                  last_byte = ({1'b0, off} + 17'd1) >= {1'b0, nlen};
                  if (bpos_in >= START_CODE_BYTES) begin
                     if (!frag_in) begin
                        // Single packet: header ahead of the first byte
                        job_push    = 1'b1;
                        job.has_hdr = (off == '0);
                        job.marker  = mark_in;
                        job.pkt_end = last_byte;
                        if (off == '0) seq_in = seq_ff + 16'd1;
                     end else if (off == '0) begin
                        // NAL header byte is folded into the FU bytes
                        nalh_in = data_byte;
                     end else begin
                        job_push = 1'b1;
                        if (fill_in == '0) begin
                           last_frag   = (nlen - off) <= {4'b0, cap};
                           job.has_hdr = 1'b1;
                           job.has_fu  = 1'b1;
                           job.marker  = last_frag && mark_in;
                           job.fu_ind  = (nalh_in & NRI_MASK) | FU_A_TYPE;
                           job.fu_hdr  = ((off == 16'd1) ? FU_START_BIT : 8'h00) |
                                         (last_frag ? FU_END_BIT : 8'h00) |
                                         (nalh_in & NAL_TYPE_MASK);
                           seq_in      = seq_ff + 16'd1;
                        end
                        fill_next   = fill_in + 12'd1;
                        job.pkt_end = (fill_next >= cap) || last_byte;
                        fill_in     = job.pkt_end ? '0 : fill_next;
                     end
                  end
                  bpos_in = bpos_in + 16'd1;
               end
            end
            default: ;
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff    <= SEQ_RST;
         ts_ff     <= '0;
         bpos_ff   <= '0;
         ulen_ff   <= '0;
         nalh_ff   <= '0;
         mark_ff   <= 1'b0;
         frag_ff   <= 1'b0;
         active_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         seq_ff    <= seq_in;
         ts_ff     <= ts_in;
         bpos_ff   <= bpos_in;
         ulen_ff   <= ulen_in;
         nalh_ff   <= nalh_in;
         mark_ff   <= mark_in;
         frag_ff   <= frag_in;
         active_ff <= active_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### rtl/rtpfua_fifo.sv
// Short job queue that decouples the front end from the byte serializer.
// Depends on rtpfua_pkg for job_type and the queue depth.
module rtpfua_fifo import rtpfua_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  job_type wr_job,
   input  logic    rd_en,
   output job_type rd_job,
   output logic    q_full,
   output logic    q_empty
);

   job_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wptr_ff, wptr_in;
   logic [QPTR_W-1:0]  rptr_ff, rptr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               do_wr, do_rd;

   assign q_full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_empty = (cnt_ff == '0);
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_job  = mem_ff[rptr_ff];

   // Pointer and count update
   always_comb begin
      wptr_in = do_wr ? wptr_ff + QPTR_W'(1) : wptr_ff;
      rptr_in = do_rd ? rptr_ff + QPTR_W'(1) : rptr_ff;
      cnt_in  = cnt_ff + QCNT_W'(do_wr) - QCNT_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Job storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wptr_ff] <= wr_job;
   end

endmodule

### rtl/rtpfua_back.sv
// Back end: walks the job at the queue head byte by byte onto the result
// ports. Depends on rtpfua_pkg.
module rtpfua_back import rtpfua_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  job_type           head,
   input  logic              head_valid,
   input  logic              pop,
   input  logic [PT_W-1:0]   payload_type,
   input  logic [WORD_W-1:0] ssrc_id,
   output logic              deq,
   output logic [7:0]        out_byte,
   output logic              packet_first,
   output logic              packet_end,
   output logic              run_last
);

   logic [CUR_W-1:0] cur_ff, cur_in;
   logic [CUR_W-1:0] pos;
   logic             step;

   // Jobs without a header go straight to the data byte
   assign pos  = head.has_hdr ? cur_ff : CUR_DATA;
   assign step = pop && head_valid;
   assign deq  = step && (pos == CUR_DATA);

   // Byte select
   always_comb begin
      case (pos)
         4'd0:         out_byte = RTP_VERSION_BYTE;
         4'd1:         out_byte = {head.marker, payload_type};
         4'd2:         out_byte = head.seq[15:8];
         4'd3:         out_byte = head.seq[7:0];
         4'd4:         out_byte = head.ts[31:24];
         4'd5:         out_byte = head.ts[23:16];
         4'd6:         out_byte = head.ts[15:8];
         4'd7:         out_byte = head.ts[7:0];
         4'd8:         out_byte = ssrc_id[31:24];
         4'd9:         out_byte = ssrc_id[23:16];
         4'd10:        out_byte = ssrc_id[15:8];
         CUR_HDR_LAST: out_byte = ssrc_id[7:0];
         CUR_FU_IND:   out_byte = head.fu_ind;
         CUR_FU_HDR:   out_byte = head.fu_hdr;
         CUR_DATA:     out_byte = head.data;
         default:      out_byte = head.data;
      endcase
   end

   assign packet_first = (pos == '0);
   assign packet_end   = (pos == CUR_DATA) && head.pkt_end;
   assign run_last     = (pos == CUR_DATA);

   // Cursor advance
   always_comb begin
      cur_in = cur_ff;
      if (step) begin
         if (pos == CUR_DATA) begin
            cur_in = '0;
         end else if (pos == CUR_HDR_LAST && !head.has_fu) begin
            cur_in = CUR_DATA;
         end else begin
            cur_in = cur_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
      end else begin
         cur_ff <= cur_in;
      end
   end

endmodule

### rtl/rtp_h264_fua_packetizer_unit.sv
// Top level of the RTP H.264 FU-A packetizer: configuration registers,
// front end, job queue and byte serializer. Depends on rtpfua_pkg.
//
// Takes one transaction per cycle unless full (Annex B byte or timestamp action)
// and delivers the packet stream one byte per cycle while pop is high. A payload
// byte that opens a packet yields 13 result bytes (single packet) or 15 (FU-A
// fragment), any other payload byte yields one, so input stalls while the
// serializer works through a header; the four-entry job queue between front end
// and serializer sets how far the input can run ahead. Start-code bytes, the NAL
// header byte of a fragmented unit, stray bytes and timestamp actions yield no
// result. Write configuration only while idle; the block does not enforce it.
module rtp_h264_fua_packetizer_unit import rtpfua_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // input channel
   input  logic                 push,
   output logic                 full,
   input  logic [ACTION_W-1:0]  req_action,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_nal_start,
   input  logic [LEN_W-1:0]     req_nal_length,
   input  logic                 req_frame_mark,
   input  logic [WORD_W-1:0]    req_ts_value,
   // result channel
   output logic                 empty,
   input  logic                 pop,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_packet_first,
   output logic                 rsp_packet_end,
   output logic                 rsp_run_last,
   // configuration port
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   logic [LIMIT_W-1:0] max_payload_ff;
   logic [PT_W-1:0]    payload_type_ff;
   logic [WORD_W-1:0]  ssrc_id_ff;

   logic    accept;
   logic    job_push;
   job_type job_wr;
   job_type job_head;
   logic    q_full, q_empty;
   logic    deq;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff  <= MAX_PAYLOAD_RST;
         payload_type_ff <= PAYLOAD_TYPE_RST;
         ssrc_id_ff      <= SSRC_ID_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_PAYLOAD:  max_payload_ff  <= csr_wdata[LIMIT_W-1:0];
            CSR_PAYLOAD_TYPE: payload_type_ff <= csr_wdata[PT_W-1:0];
            CSR_SSRC_ID:      ssrc_id_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign full   = q_full;
   assign empty  = q_empty;
   assign accept = push && !q_full;

   rtpfua_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .action      (req_action),
      .data_byte   (req_data_byte),
      .nal_start   (req_nal_start),
      .nal_length  (req_nal_length),
      .frame_mark  (req_frame_mark),
      .ts_value    (req_ts_value),
      .max_payload (max_payload_ff),
      .job_push    (job_push),
      .job         (job_wr)
   );

   rtpfua_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_push),
      .wr_job  (job_wr),
      .rd_en   (deq),
      .rd_job  (job_head),
      .q_full  (q_full),
      .q_empty (q_empty)
   );

   rtpfua_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (job_head),
      .head_valid   (!q_empty),
      .pop          (pop),
      .payload_type (payload_type_ff),
      .ssrc_id      (ssrc_id_ff),
      .deq          (deq),
      .out_byte     (rsp_out_byte),
      .packet_first (rsp_packet_first),
      .packet_end   (rsp_packet_end),
      .run_last     (rsp_run_last)
   );

endmodule

### rtl/rtpfua_checker.sv
// Port-level checks for the packetizer, bound to the top level.
// Depends on rtpfua_pkg and rtp_h264_fua_packetizer_unit.
module rtpfua_checker import rtpfua_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       empty,
   input logic       pop,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_packet_first,
   input logic       rsp_packet_end,
   input logic       rsp_run_last
);

   // Reset drains all pending results
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("results pending after reset");

   // A waiting result holds while not taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_byte)))
      else $error("stalled result changed");

   // A packet starts with the version byte and never ends a transaction there
   a_first_byte: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_packet_first) |->
      (rsp_out_byte == RTP_VERSION_BYTE && !rsp_run_last && !rsp_packet_end))
      else $error("bad first header byte");

   // Packet end only falls on a data byte
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_packet_end) |-> rsp_run_last)
      else $error("packet end outside data byte");

   // The byte after a header start is still header
   a_hdr_cont: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && rsp_packet_first) |=> (!empty && !rsp_packet_first))
      else $error("header cut short");

endmodule

bind rtp_h264_fua_packetizer_unit rtpfua_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .empty            (empty),
   .pop              (pop),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_packet_first (rsp_packet_first),
   .rsp_packet_end   (rsp_packet_end),
   .rsp_run_last     (rsp_run_last)
);
